// ===== rtl/core/sht_pkg.sv =====
// Shared types and codes for the shape hit tester.
`timescale 1ns / 1ps

package sht_pkg;

   localparam int EXT_BITS = 15;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [1:0] SHAPE_RECT    = 2'd0;
   localparam logic [1:0] SHAPE_CIRCLE  = 2'd1;
   localparam logic [1:0] SHAPE_POLYGON = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SHAPE_KIND = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTENT_X   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTENT_Y   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CIRC,
      ST_FIRST,
      ST_LOAD0,
      ST_WAIT,
      ST_EDGE,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_CROSS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== rtl/core/sht_if.sv =====
// Channel interfaces for query beats and result beats.
`timescale 1ns / 1ps

interface sht_req_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   modport source (output valid, mode, point_x, point_y, input ready);
   modport sink (input valid, mode, point_x, point_y, output ready);
endinterface

interface sht_rsp_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic                         inside_res;
   logic [1:0]                   status;
   logic [COORD_BITS:0]          box_width;
   logic [COORD_BITS:0]          box_height;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   modport source (output valid, inside_res, status, box_width, box_height, center_x,
                   center_y, input ready);
   modport sink (input valid, inside_res, status, box_width, box_height, center_x,
                 center_y, output ready);
endinterface

// ===== rtl/core/shape_hit_test_top.sv =====
// Top level of the shape hit tester: sequencer, vertex table and result register.
// Polygon query over N vertices: each edge that needs a crossing point waits on
// the bit-serial divider, which is shared by all edges.
// One item at a time; the next beat is taken once the result is in the output register.
// Synchronous reset empties the vertex table and box, shape kind becomes polygon.
`timescale 1ns / 1ps

module shape_hit_test_top #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   sht_req_if.sink                         req_if,
   sht_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [sht_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [sht_pkg::EXT_BITS-1:0]     csr_wdata
);

   localparam int CB = COORD_BITS;
   localparam int XB = sht_pkg::EXT_BITS;
   localparam int MW = (CB + 1 > XB) ? CB + 1 : XB;
   localparam int PW = 2 * MW;
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int IW = $clog2(MAX_VERTICES + 1);
   localparam int SW = ((CB > XB) ? CB : XB) + 2;

   sht_pkg::state_type state_ff, state_in;

   logic [1:0]    shape_ff;
   logic [XB-1:0] ext_x_ff, ext_y_ff;

   logic signed [CB-1:0] mem_x [MAX_VERTICES];
   logic signed [CB-1:0] mem_y [MAX_VERTICES];
   logic signed [CB-1:0] rd_x_ff, rd_y_ff;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;

   logic [IW-1:0]        count_ff, count_in, idx_ff, idx_in;
   logic signed [CB-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [CB-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic signed [CB-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [CB-1:0] prev_x_ff, prev_y_ff, prev_x_in, prev_y_in;
   logic [1:0]           circ_step_ff, circ_step_in;
   logic [PW:0]          acc_ff, acc_in;
   logic [1:0]           lt_ff, gt_ff, lt_in, gt_in;
   logic                 inside_ff, inside_in;
   logic [1:0]           status_ff, status_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_inside_ff;
   logic [1:0]                   rsp_status_ff;
   logic [CB:0]                  rsp_w_ff, rsp_h_ff;
   logic signed [CB-1:0]         rsp_cx_ff, rsp_cy_ff;
   logic                         load_rsp;
   logic [CB:0]                  box_w, box_h;

   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] prod;
   logic          div_start;
   logic [PW-1:0] quotient;
   sht_pkg::div_stat_type div_stat;

   // Edge datapath
   logic signed [CB:0]   ea, eb, ec;
   logic [CB:0]          ma, mb, mc;
   logic                 span0, span1, all_lt, all_gt, flat, need_cross, neg;
   logic signed [PW+1:0] qs, xc, px_w;
   logic [CB:0]          ax_m, ay_m;
   logic signed [SW-1:0] px_s, py_s, hw_s, hh_s;

   logic accept;
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == sht_pkg::ST_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= sht_pkg::SHAPE_POLYGON;
         ext_x_ff <= '0;
         ext_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sht_pkg::CSR_SHAPE_KIND: shape_ff <= csr_wdata[1:0];
            sht_pkg::CSR_EXTENT_X:   ext_x_ff <= csr_wdata;
            sht_pkg::CSR_EXTENT_Y:   ext_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Vertex table
   assign mem_we  = accept && (req_if.mode == sht_pkg::MODE_APPEND) &&
                    (count_ff != IW'(MAX_VERTICES));
   assign rd_addr = (idx_ff == count_ff) ? '0 : idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[count_ff[AW-1:0]] <= req_if.point_x;
         mem_y[count_ff[AW-1:0]] <= req_if.point_y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   // Edge arithmetic: prev vertex to the vertex just read
   assign ea   = {py_ff[CB-1], py_ff} - {prev_y_ff[CB-1], prev_y_ff};
   assign eb   = {rd_x_ff[CB-1], rd_x_ff} - {prev_x_ff[CB-1], prev_x_ff};
   assign ec   = {rd_y_ff[CB-1], rd_y_ff} - {prev_y_ff[CB-1], prev_y_ff};
   assign ma   = ea[CB] ? -ea : ea;
   assign mb   = eb[CB] ? -eb : eb;
   assign mc   = ec[CB] ? -ec : ec;
   assign flat = (prev_y_ff == rd_y_ff);
   assign span0 = (prev_y_ff < py_ff && rd_y_ff >= py_ff) ||
                  (prev_y_ff >= py_ff && rd_y_ff < py_ff);
   assign span1 = (prev_y_ff <= py_ff && rd_y_ff > py_ff) ||
                  (prev_y_ff > py_ff && rd_y_ff <= py_ff);
   assign all_lt = (prev_x_ff < px_ff) && (rd_x_ff < px_ff);
   assign all_gt = (prev_x_ff > px_ff) && (rd_x_ff > px_ff);
   assign need_cross = (span0 || span1) && !all_lt && !all_gt;
   assign neg  = (ea[CB] ^ eb[CB] ^ ec[CB]) && (ea != '0) && (eb != '0);
   assign qs   = $signed({2'b00, quotient});
   assign px_w = $signed({{(PW+2-CB){px_ff[CB-1]}}, px_ff});
   assign xc   = (neg ? -qs : qs) + $signed({{(PW+2-CB){prev_x_ff[CB-1]}}, prev_x_ff});

   // Circle and rectangle operands
   assign ax_m = px_ff[CB-1] ? -{px_ff[CB-1], px_ff} : {px_ff[CB-1], px_ff};
   assign ay_m = py_ff[CB-1] ? -{py_ff[CB-1], py_ff} : {py_ff[CB-1], py_ff};
   assign px_s = $signed({{(SW-CB){req_if.point_x[CB-1]}}, req_if.point_x});
   assign py_s = $signed({{(SW-CB){req_if.point_y[CB-1]}}, req_if.point_y});
   assign hw_s = $signed(SW'(ext_x_ff >> 1));
   assign hh_s = $signed(SW'(ext_y_ff >> 1));

   always_comb begin
      mul_a = MW'(mb);
      mul_b = MW'(ma);
      if (state_ff == sht_pkg::ST_CIRC) begin
         unique case (circ_step_ff)
            2'd0:    begin mul_a = MW'(ax_m); mul_b = MW'(ax_m); end
            2'd1:    begin mul_a = MW'(ay_m); mul_b = MW'(ay_m); end
            default: begin mul_a = MW'(ext_x_ff); mul_b = MW'(ext_x_ff); end
         endcase
      end
   end

   sht_mul #(.W(MW)) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign div_start = (state_ff == sht_pkg::ST_DSTART);

   sht_divider #(.NW(PW), .DW(MW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (MW'(mc)),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // Sequencer
   always_comb begin
      logic       adv;
      logic       cross_gt;
      logic [1:0] lt_n, gt_n;
      adv          = 1'b0;
      cross_gt     = xc > px_w;
      lt_n         = lt_ff;
      gt_n         = gt_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      min_x_in     = min_x_ff;
      max_x_in     = max_x_ff;
      min_y_in     = min_y_ff;
      max_y_in     = max_y_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      circ_step_in = circ_step_ff;
      acc_in       = acc_ff;
      inside_in    = inside_ff;
      status_in    = status_ff;
      load_rsp     = 1'b0;

      unique case (state_ff)
         sht_pkg::ST_IDLE: begin
            if (accept) begin
               px_in     = req_if.point_x;
               py_in     = req_if.point_y;
               inside_in = 1'b0;
               status_in = sht_pkg::STATUS_OK;
               state_in  = sht_pkg::ST_DONE;
               if (req_if.mode == sht_pkg::MODE_CLEAR) begin
                  count_in = '0;
                  min_x_in = '0;
                  max_x_in = '0;
                  min_y_in = '0;
                  max_y_in = '0;
               end else if (req_if.mode == sht_pkg::MODE_APPEND) begin
                  if (count_ff == IW'(MAX_VERTICES)) begin
                     status_in = sht_pkg::STATUS_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                     if (count_ff == '0) begin
                        min_x_in = req_if.point_x;
                        max_x_in = req_if.point_x;
                        min_y_in = req_if.point_y;
                        max_y_in = req_if.point_y;
                     end else begin
                        if (req_if.point_x < min_x_ff) min_x_in = req_if.point_x;
                        if (req_if.point_x > max_x_ff) max_x_in = req_if.point_x;
                        if (req_if.point_y < min_y_ff) min_y_in = req_if.point_y;
                        if (req_if.point_y > max_y_ff) max_y_in = req_if.point_y;
                     end
                  end
               end else if (req_if.mode == sht_pkg::MODE_QUERY) begin
                  if (shape_ff == sht_pkg::SHAPE_RECT) begin
                     inside_in = (px_s >= -hw_s) && (px_s < hw_s) &&
                                 (py_s >= -hh_s) && (py_s < hh_s);
                  end else if (shape_ff == sht_pkg::SHAPE_CIRCLE) begin
                     circ_step_in = 2'd0;
                     state_in     = sht_pkg::ST_CIRC;
                  end else if (shape_ff == sht_pkg::SHAPE_POLYGON) begin
                     if (count_ff == '0) begin
                        status_in = sht_pkg::STATUS_EMPTY;
                     end else begin
                        idx_in   = '0;
                        lt_n     = 2'b00;
                        gt_n     = 2'b00;
                        state_in = sht_pkg::ST_FIRST;
                     end
                  end
               end
            end
         end
         sht_pkg::ST_CIRC: begin
            // product of the previous step comes from the multiplier register
            circ_step_in = circ_step_ff + 1'b1;
            unique case (circ_step_ff)
               2'd0: ;
               2'd1: acc_in = {1'b0, prod};
               2'd2: acc_in = acc_ff + {1'b0, prod};
               default: begin
                  inside_in = (acc_ff <= {1'b0, prod});
                  state_in  = sht_pkg::ST_DONE;
               end
            endcase
         end
         sht_pkg::ST_FIRST: state_in = sht_pkg::ST_LOAD0;
         sht_pkg::ST_LOAD0: begin
            prev_x_in = rd_x_ff;
            prev_y_in = rd_y_ff;
            idx_in    = IW'(1);
            state_in  = sht_pkg::ST_WAIT;
         end
         sht_pkg::ST_WAIT: state_in = sht_pkg::ST_EDGE;
         sht_pkg::ST_EDGE: begin
            if (flat) begin
               adv = 1'b1;
            end else if (need_cross) begin
               state_in = sht_pkg::ST_MUL;
            end else begin
               adv = 1'b1;
               if (span0) begin
                  if (all_lt) lt_n[0] = ~lt_ff[0];
                  else        gt_n[0] = 1'b1;
               end
               if (span1) begin
                  if (all_lt) lt_n[1] = ~lt_ff[1];
                  else        gt_n[1] = 1'b1;
               end
            end
         end
         sht_pkg::ST_MUL:    state_in = sht_pkg::ST_DSTART;
         sht_pkg::ST_DSTART: state_in = sht_pkg::ST_DIV;
         sht_pkg::ST_DIV: begin
            if (div_stat.done) state_in = sht_pkg::ST_CROSS;
         end
         sht_pkg::ST_CROSS: begin
            if (xc == px_w) begin
               inside_in = 1'b1;
               state_in  = sht_pkg::ST_DONE;
            end else begin
               adv = 1'b1;
               if (span0) begin
                  if (cross_gt) gt_n[0] = 1'b1;
                  else          lt_n[0] = ~lt_ff[0];
               end
               if (span1) begin
                  if (cross_gt) gt_n[1] = 1'b1;
                  else          lt_n[1] = ~lt_ff[1];
               end
            end
         end
         sht_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp = 1'b1;
               state_in = sht_pkg::ST_IDLE;
            end
         end
         default: state_in = sht_pkg::ST_IDLE;
      endcase

      if (adv) begin
         prev_x_in = rd_x_ff;
         prev_y_in = rd_y_ff;
         if (idx_ff == count_ff) begin
            inside_in = (lt_n[0] && gt_n[0]) || (lt_n[1] && gt_n[1]);
            state_in  = sht_pkg::ST_DONE;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = sht_pkg::ST_WAIT;
         end
      end
      lt_in = lt_n;
      gt_in = gt_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sht_pkg::ST_IDLE;
         count_ff <= '0;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
      idx_ff       <= idx_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      circ_step_ff <= circ_step_in;
      acc_ff       <= acc_in;
      lt_ff        <= lt_in;
      gt_ff        <= gt_in;
      inside_ff    <= inside_in;
      status_ff    <= status_in;
   end

   // Output register
   assign box_w = {max_x_ff[CB-1], max_x_ff} - {min_x_ff[CB-1], min_x_ff} + 1'b1;
   assign box_h = {max_y_ff[CB-1], max_y_ff} - {min_y_ff[CB-1], min_y_ff} + 1'b1;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_inside_ff <= inside_ff;
         rsp_status_ff <= status_ff;
         if (count_ff == '0) begin
            rsp_w_ff  <= '0;
            rsp_h_ff  <= '0;
            rsp_cx_ff <= '0;
            rsp_cy_ff <= '0;
         end else begin
            rsp_w_ff  <= box_w;
            rsp_h_ff  <= box_h;
            rsp_cx_ff <= min_x_ff + $signed(box_w[CB:1]);
            rsp_cy_ff <= min_y_ff + $signed(box_h[CB:1]);
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.inside_res = rsp_inside_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.box_width  = rsp_w_ff;
   assign rsp_if.box_height = rsp_h_ff;
   assign rsp_if.center_x   = rsp_cx_ff;
   assign rsp_if.center_y   = rsp_cy_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IW'(MAX_VERTICES))
      else $error("vertex count beyond table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.mode == sht_pkg::MODE_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the table");

   a_div_to_cross: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sht_pkg::ST_DIV && div_stat.done) |=> (state_ff == sht_pkg::ST_CROSS))
      else $error("divider finish not followed by crossing step");

   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sht_pkg::ST_DSTART) |-> !div_stat.busy)
      else $error("divider restarted while busy");

endmodule

// ===== rtl/core/sht_mul.sv =====
// Shared registered unsigned multiplier.
`timescale 1ns / 1ps

module sht_mul #(
   parameter int W = 17
) (
   input  logic           clock,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic [2*W-1:0] prod
);

   logic [2*W-1:0] prod_ff;
   logic [2*W-1:0] prod_in;

   assign prod_in = {{W{1'b0}}, op_a} * {{W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/sht_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sht_divider #(
   parameter int NW = 34,
   parameter int DW = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NW-1:0]         dividend,
   input  logic [DW-1:0]         divisor,
   output logic [NW-1:0]         quotient,
   output sht_pkg::div_stat_type stat
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   shifted;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff[DW-1:0], quo_ff[NW-1]};
      if (start) begin
         cnt_in = CW'(NW);
         rem_in = '0;
         quo_in = dividend;
      end else if (cnt_ff != '0) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = shifted - {1'b0, divisor};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule
